@@ rtl/group_cache_reload_planner_top_macros.svh @@
// Assertion helpers shared by the planner RTL. They expect clk and rst in scope.
`ifndef GROUP_CACHE_RELOAD_PLANNER_TOP_MACROS_SVH
`define GROUP_CACHE_RELOAD_PLANNER_TOP_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define GCRP_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define GCRP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define GCRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gcrp_pkg.sv @@
package gcrp_pkg;

  localparam int MAX_GROUPS = 1024;
  localparam int GROUP_W = $clog2(MAX_GROUPS);
  localparam int COUNT_W = GROUP_W + 1;

  typedef logic [GROUP_W-1:0] group_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Slot map entry: the top bit set means the group holds no slot.
  localparam count_t NOT_RES = '1;

  typedef enum logic [1:0] {
    OP_SCAN         = 2'd0,
    OP_INIT         = 2'd1,
    OP_LOOKUP_GROUP = 2'd2,
    OP_LOOKUP_SLOT  = 2'd3
  } opcode_t;

  localparam logic [1:0] CFG_GROUP_COUNT  = 2'd0;
  localparam logic [1:0] CFG_CACHED_COUNT = 2'd1;
  localparam logic [1:0] CFG_RELOAD_LIMIT = 2'd2;

  // Effective (clamped) configuration.
  typedef struct packed {
    count_t groups;
    count_t cached;
    count_t budget;
  } cfg_t;

  typedef struct packed {
    logic   push;
    group_t push_data;
    logic   pop;
    logic   clear;
  } fifo_req_t;

  typedef struct packed {
    group_t sog_raddr;
    logic   sog_we;
    group_t sog_waddr;
    count_t sog_wdata;
    group_t gis_raddr;
    logic   gis_we;
    group_t gis_waddr;
    group_t gis_wdata;
  } map_req_t;

  typedef struct packed {
    logic   resident;
    group_t slot;
    group_t group_id;
  } map_rsp_t;

  typedef struct packed {
    logic   pair_valid;
    group_t loaded_group;
    group_t evicted_group;
    group_t slot_number;
    logic   plan_done;
    count_t planned_pairs;
    count_t applied_pairs;
    logic   count_mismatch;
    logic   bad_evict;
    logic   lookup_hit;
    group_t lookup_value;
  } result_t;

endpackage

@@ rtl/gcrp_fifo.sv @@
module gcrp_fifo
  import gcrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  fifo_req_t req,
  output group_t    head_data
);

  group_t mem [MAX_GROUPS];
  group_t head;
  group_t tail;
  group_t head_next;

  always_comb begin
    if (req.clear) begin
      head_next = '0;
    end else if (req.pop) begin
      head_next = head + group_t'(1);
    end else begin
      head_next = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      head <= head_next;
      if (req.clear) begin
        tail <= '0;
      end else if (req.push) begin
        tail <= tail + group_t'(1);
      end
    end
  end

  // Reading the next head shows the current head, bar a write to it in the same cycle.
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail] <= req.push_data;
    end
    head_data <= mem[head_next];
  end

endmodule

@@ rtl/gcrp_map.sv @@
module gcrp_map
  import gcrp_pkg::*;
(
  input  logic     clk,
  input  map_req_t req,
  output map_rsp_t rsp
);

  count_t sog_mem [MAX_GROUPS];
  group_t gis_mem [MAX_GROUPS];
  count_t sog_q;
  group_t gis_q;

  always_ff @(posedge clk) begin
    if (req.sog_we) begin
      sog_mem[req.sog_waddr] <= req.sog_wdata;
    end
    sog_q <= sog_mem[req.sog_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.gis_we) begin
      gis_mem[req.gis_waddr] <= req.gis_wdata;
    end
    gis_q <= gis_mem[req.gis_raddr];
  end

  assign rsp.resident = ~sog_q[COUNT_W-1];
  assign rsp.slot     = sog_q[GROUP_W-1:0];
  assign rsp.group_id = gis_q;

endmodule

@@ rtl/gcrp_ctrl.sv @@
`include "group_cache_reload_planner_top_macros.svh"

module gcrp_ctrl
  import gcrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  opcode_t   in_op,
  input  logic      in_load,
  input  logic      in_evict,
  input  group_t    in_index,
  input  cfg_t      cfg,
  output fifo_req_t fifo_req,
  input  group_t    fifo_head,
  output map_req_t  map_req,
  input  map_rsp_t  map_rsp,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   result
);

  typedef enum logic [3:0] {
    ST_WALK,
    ST_IDLE,
    ST_POP,
    ST_READ,
    ST_WR2,
    ST_LKG,
    ST_LKS1,
    ST_LKS2,
    ST_FINISH
  } state_t;

  state_t  state;
  opcode_t op_q;
  group_t  idx_q;
  group_t  g_q;
  logic    pop_ev_q;
  logic    pop_ld_q;
  logic    in_budget_q;
  logic    last_q;
  logic    bad_q;
  logic    applied_q;
  group_t  pl_q;
  group_t  pe_q;
  group_t  slot_q;
  logic    lk_hit;
  group_t  lk_val;
  group_t  walk_idx;
  count_t  walk_lim;
  group_t  scan_pos;
  count_t  n_loads;
  count_t  n_evicts;
  count_t  n_applied;

  logic    accept;
  logic    eq;
  logic    lgt;
  logic    egt;
  logic    self_pair;
  logic    pop_ev;
  logic    pop_ld;
  logic    push;
  count_t  pairs_before;
  logic    in_budget;
  logic    at_last;
  logic    walk_in;
  group_t  pl_sel;
  group_t  pe_sel;
  logic    is_scan;
  logic    emit;
  logic    out_load;
  logic    finish_go;
  result_t result_next;

  always_comb begin
    in_ready     = (state == ST_IDLE);
    accept       = in_valid && in_ready;
    eq           = (n_loads == n_evicts);
    lgt          = (n_loads > n_evicts);
    egt          = (n_evicts > n_loads);
    // Both flags with nothing pending pair the group with itself.
    self_pair    = in_load && in_evict && eq;
    pop_ev       = in_evict && !self_pair && lgt;
    pop_ld       = in_load && !self_pair && egt;
    push         = (in_evict && !self_pair && !lgt) || (in_load && !self_pair && !egt);
    pairs_before = lgt ? n_evicts : n_loads;
    in_budget    = (self_pair || pop_ev || pop_ld) && (pairs_before < cfg.budget);
    at_last      = {1'b0, scan_pos} >= (cfg.groups - count_t'(1));
    walk_in      = {1'b0, walk_idx} < walk_lim;
    pl_sel       = pop_ev_q ? fifo_head : g_q;
    pe_sel       = pop_ld_q ? fifo_head : g_q;
    is_scan      = (op_q == OP_SCAN);
    emit         = !is_scan || in_budget_q || last_q;
    out_load     = (state == ST_FINISH) && emit && (!out_valid || out_ready);
    finish_go    = (state == ST_FINISH) && (!emit || !out_valid || out_ready);
  end

  always_comb begin
    result_next.pair_valid     = is_scan && applied_q;
    result_next.loaded_group   = (is_scan && in_budget_q) ? pl_q : '0;
    result_next.evicted_group  = (is_scan && in_budget_q) ? pe_q : '0;
    result_next.slot_number    = (is_scan && applied_q) ? slot_q : '0;
    result_next.plan_done      = is_scan && last_q;
    result_next.planned_pairs  = (is_scan && last_q) ? n_loads : '0;
    result_next.applied_pairs  = (is_scan && last_q) ? n_applied : '0;
    result_next.count_mismatch = is_scan && last_q && (n_loads != n_evicts);
    result_next.bad_evict      = is_scan && bad_q;
    result_next.lookup_hit     = !is_scan && lk_hit;
    result_next.lookup_value   = is_scan ? '0 : lk_val;
  end

  always_comb begin
    fifo_req.push      = accept && (in_op == OP_SCAN) && push;
    fifo_req.push_data = scan_pos;
    fifo_req.pop       = (state == ST_POP) && (pop_ev_q || pop_ld_q);
    fifo_req.clear     = (accept && (in_op == OP_INIT)) || (finish_go && is_scan && last_q);
  end

  always_comb begin
    map_req           = '0;
    map_req.sog_raddr = in_index;
    map_req.gis_raddr = in_index;
    case (state)
      ST_WALK: begin
        map_req.sog_we    = 1'b1;
        map_req.sog_waddr = walk_idx;
        map_req.sog_wdata = walk_in ? {1'b0, walk_idx} : NOT_RES;
        map_req.gis_we    = walk_in;
        map_req.gis_waddr = walk_idx;
        map_req.gis_wdata = walk_idx;
      end
      ST_POP: begin
        map_req.sog_raddr = pe_sel;
      end
      ST_READ: begin
        // The evicted group gives up its slot; the slot now names the loaded group.
        map_req.sog_we    = map_rsp.resident;
        map_req.sog_waddr = pe_q;
        map_req.sog_wdata = NOT_RES;
        map_req.gis_we    = map_rsp.resident;
        map_req.gis_waddr = map_rsp.slot;
        map_req.gis_wdata = pl_q;
      end
      ST_WR2: begin
        map_req.sog_we    = 1'b1;
        map_req.sog_waddr = pl_q;
        map_req.sog_wdata = {1'b0, slot_q};
      end
      ST_LKS1: begin
        map_req.sog_raddr = map_rsp.group_id;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WALK;
      walk_idx  <= '0;
      walk_lim  <= '0;
      scan_pos  <= '0;
      n_loads   <= '0;
      n_evicts  <= '0;
      n_applied <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        result <= result_next;
      end

      case (state)
        ST_WALK: begin
          walk_idx <= walk_idx + group_t'(1);
          if (walk_idx == group_t'(MAX_GROUPS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_q  <= in_op;
            idx_q <= in_index;
            g_q   <= scan_pos;
            case (in_op)
              OP_SCAN: begin
                pop_ev_q    <= pop_ev;
                pop_ld_q    <= pop_ld;
                in_budget_q <= in_budget;
                last_q      <= at_last;
                bad_q       <= 1'b0;
                applied_q   <= 1'b0;
                if (in_load) begin
                  n_loads <= n_loads + count_t'(1);
                end
                if (in_evict) begin
                  n_evicts <= n_evicts + count_t'(1);
                end
                if (!at_last) begin
                  scan_pos <= scan_pos + group_t'(1);
                end
                state <= ST_POP;
              end
              OP_INIT: begin
                walk_lim  <= cfg.cached;
                walk_idx  <= '0;
                scan_pos  <= '0;
                n_loads   <= '0;
                n_evicts  <= '0;
                n_applied <= '0;
                state     <= ST_WALK;
              end
              OP_LOOKUP_GROUP: begin
                state <= ST_LKG;
              end
              OP_LOOKUP_SLOT: begin
                state <= ST_LKS1;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_POP: begin
          pl_q  <= pl_sel;
          pe_q  <= pe_sel;
          state <= in_budget_q ? ST_READ : ST_FINISH;
        end
        ST_READ: begin
          if (map_rsp.resident) begin
            slot_q <= map_rsp.slot;
            state  <= ST_WR2;
          end else begin
            bad_q <= 1'b1;
            state <= ST_FINISH;
          end
        end
        ST_WR2: begin
          n_applied <= n_applied + count_t'(1);
          applied_q <= 1'b1;
          state     <= ST_FINISH;
        end
        ST_LKG: begin
          lk_hit <= map_rsp.resident;
          lk_val <= map_rsp.resident ? map_rsp.slot : '0;
          state  <= ST_FINISH;
        end
        ST_LKS1: begin
          lk_val <= map_rsp.group_id;
          state  <= ST_LKS2;
        end
        ST_LKS2: begin
          // The slot is occupied only if its group points back at it.
          lk_hit <= map_rsp.resident && (map_rsp.slot == idx_q);
          if (!(map_rsp.resident && (map_rsp.slot == idx_q))) begin
            lk_val <= '0;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_go) begin
            if (is_scan && last_q) begin
              scan_pos  <= '0;
              n_loads   <= '0;
              n_evicts  <= '0;
              n_applied <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `GCRP_ASSERT_NEXT(a_plan_end_clears, out_load && result_next.plan_done,
                    (n_loads == '0) && (n_evicts == '0) && (scan_pos == '0),
                    "plan end did not clear the scan state")
  `GCRP_ASSERT_HOLDS(a_applied_bound, (n_applied <= n_loads) && (n_applied <= n_evicts),
                     "applied pairs exceed formed pairs")
  `GCRP_ASSERT_IMPLIES(a_pair_or_bad, out_valid, !(result.pair_valid && result.bad_evict),
                       "a pair was both applied and rejected")
  `GCRP_ASSERT_IMPLIES(a_lookup_alone, out_valid && result.lookup_hit,
                       !result.pair_valid && !result.plan_done,
                       "lookup result carries scan fields")

endmodule

@@ rtl/group_cache_reload_planner_top.sv @@
// Channel   Direction  Transfer when                  Carries
// s_axis    in         s_axis_tvalid & s_axis_tready  opcode, load/evict flags, lookup index
// m_axis    out        m_axis_tvalid & m_axis_tready  pair, plan counts, lookup answer
// cfg       in         cfg_valid & cfg_ready          register index and 11-bit value
//
// A scan entry steps through pop and, within the budget, a slot map read and write, plus a
// second write for an applied pair, as the map reads are registered and each of its arrays
// has a single write port; a lookup takes one or two map reads, and items go one at a time.
// Init map walks all 1024 map entries, one per cycle, and accepts nothing meanwhile.
// After reset the same walk clears the slot map before the first transfer in.
// Reset is synchronous; a result not taken stalls the next item with one in its last step.
module group_cache_reload_planner_top
  import gcrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // load_flag, evict_flag, lookup_index[9:0], zero fill
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // loaded_group, evicted_group, slot_number,
                                      // planned_pairs, applied_pairs, count_mismatch,
                                      // lookup_value, zero fill
  output logic [2:0]  m_axis_tuser,   // pair_valid, bad_evict, lookup_hit
  output logic        m_axis_tlast,   // plan_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  count_t    group_count;
  count_t    cached_group_count;
  count_t    reload_limit;
  cfg_t      cfg;
  fifo_req_t fifo_req;
  group_t    fifo_head;
  map_req_t  map_req;
  map_rsp_t  map_rsp;
  result_t   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count        <= count_t'(MAX_GROUPS);
      cached_group_count <= count_t'(MAX_GROUPS);
      reload_limit       <= count_t'(MAX_GROUPS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GROUP_COUNT:  group_count        <= cfg_data;
        CFG_CACHED_COUNT: cached_group_count <= cfg_data;
        CFG_RELOAD_LIMIT: reload_limit       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Each limit is clamped to one through the limit above it.
  always_comb begin
    if (group_count == '0) begin
      cfg.groups = count_t'(1);
    end else if (group_count > count_t'(MAX_GROUPS)) begin
      cfg.groups = count_t'(MAX_GROUPS);
    end else begin
      cfg.groups = group_count;
    end
    if (cached_group_count == '0) begin
      cfg.cached = count_t'(1);
    end else if (cached_group_count > cfg.groups) begin
      cfg.cached = cfg.groups;
    end else begin
      cfg.cached = cached_group_count;
    end
    if (reload_limit == '0) begin
      cfg.budget = count_t'(1);
    end else if (reload_limit > cfg.cached) begin
      cfg.budget = cfg.cached;
    end else begin
      cfg.budget = reload_limit;
    end
  end

  gcrp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .req       (fifo_req),
    .head_data (fifo_head)
  );

  gcrp_map u_map (
    .clk (clk),
    .req (map_req),
    .rsp (map_rsp)
  );

  gcrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (opcode_t'(s_axis_tuser)),
    .in_load   (s_axis_tdata[0]),
    .in_evict  (s_axis_tdata[1]),
    .in_index  (s_axis_tdata[11:2]),
    .cfg       (cfg),
    .fifo_req  (fifo_req),
    .fifo_head (fifo_head),
    .map_req   (map_req),
    .map_rsp   (map_rsp),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (result)
  );

  assign m_axis_tdata = {1'b0, result.lookup_value, result.count_mismatch,
                         result.applied_pairs, result.planned_pairs, result.slot_number,
                         result.evicted_group, result.loaded_group};
  assign m_axis_tuser = {result.lookup_hit, result.bad_evict, result.pair_valid};
  assign m_axis_tlast = result.plan_done;

endmodule
